>>> rtl/skdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skdp_pkg: shared types and constants for the Stirling number core
// Payload structs, row-store entry format, controller commands and status.
// ----------------------------------------------------------------------------
package skdp_pkg;

  localparam int MAX_COUNT  = 63;
  localparam int VALUE_BITS = 64;
  localparam int IN_W       = 6;
  localparam int WAYS_W     = 63;
  localparam int DEPTH      = MAX_COUNT + 1;
  localparam int CNT_W      = $clog2(DEPTH);
  localparam int MAG_W      = VALUE_BITS - 1;
  localparam int PROD_W     = CNT_W + MAG_W;
  localparam int SUM_W      = PROD_W + 1;

  typedef struct packed {
    logic [IN_W-1:0] elements;
    logic [IN_W-1:0] subsets;
  } skdp_query_t;

  typedef struct packed {
    logic [WAYS_W-1:0] ways;
    logic              overflow;
  } skdp_result_t;

  // One row-store word: saturation mark plus magnitude.
  typedef struct packed {
    logic             sat;
    logic [MAG_W-1:0] mag;
  } skdp_entry_t;

  localparam int ENTRY_W = $bits(skdp_entry_t);

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_INIT,
    OP_ROW_START,
    OP_FETCH,
    OP_STEP,
    OP_ROW_END,
    OP_READOUT
  } skdp_op_t;

  typedef struct packed {
    skdp_op_t op;
    logic     out_load;
  } skdp_cmd_t;

  typedef struct packed {
    logic init_done;
    logic n_zero;
    logic k_zero;
    logic last_col;
    logic last_row;
  } skdp_status_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [IN_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (int'(v) > MAX_COUNT) begin
      r = CNT_W'(MAX_COUNT);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/skdp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skdp_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skdp_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/skdp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skdp_datapath: row store, counters and saturating multiply-add
// Executes one controller command per cycle; one column update per step.
// ----------------------------------------------------------------------------
module skdp_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  skdp_pkg::skdp_cmd_t    cmd,
  input  skdp_pkg::skdp_query_t  query,
  output skdp_pkg::skdp_status_t status,
  output skdp_pkg::skdp_result_t result
);

  import skdp_pkg::*;

  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  k_q;
  logic [CNT_W-1:0]  i_cnt;
  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  col_dec;
  logic [PROD_W-1:0] prod;
  logic              sat_a;
  logic [SUM_W-1:0]  sum;
  logic              step_sat;

  logic               ram_we;
  logic [CNT_W-1:0]   ram_waddr;
  skdp_entry_t        ram_wdata;
  logic [CNT_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  skdp_entry_t        rd;

  skdp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd       = skdp_entry_t'(ram_rdata);
  assign col_dec  = col - CNT_W'(1);
  // j*S(i-1,j) + S(i-1,j-1); anything above the magnitude width saturates
  assign sum      = SUM_W'(prod) + SUM_W'(rd.mag);
  assign step_sat = sat_a | rd.sat | (sum[SUM_W-1:MAG_W] != '0);

  assign status.init_done = (col == k_q);
  assign status.n_zero    = (n_q == '0);
  assign status.k_zero    = (k_q == '0);
  assign status.last_col  = (col == CNT_W'(1));
  assign status.last_row  = (i_cnt == n_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = col;
    ram_wdata = '0;
    ram_raddr = k_q;
    unique case (cmd.op)
      OP_INIT: begin
        ram_we = 1'b1;
        if (col == '0) begin
          ram_wdata.mag = MAG_W'(1);
        end
      end
      OP_FETCH: begin
        ram_raddr = col_dec;
      end
      OP_STEP: begin
        ram_we    = 1'b1;
        ram_raddr = col - CNT_W'(2);
        if (step_sat) begin
          ram_wdata.sat = 1'b1;
          ram_wdata.mag = '1;
        end else begin
          ram_wdata.mag = sum[MAG_W-1:0];
        end
      end
      OP_ROW_END: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
      end
      OP_IDLE, OP_LOAD, OP_ROW_START, OP_READOUT: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        n_q   <= clamp_count(query.elements);
        k_q   <= clamp_count(query.subsets);
        col   <= '0;
        i_cnt <= '0;
      end
      OP_INIT: begin
        col <= col + CNT_W'(1);
      end
      OP_ROW_START: begin
        i_cnt <= i_cnt + CNT_W'(1);
        col   <= k_q;
      end
      OP_FETCH: begin
        prod  <= PROD_W'(col) * PROD_W'(rd.mag);
        sat_a <= rd.sat;
      end
      OP_STEP: begin
        // the old S(i-1,j-1) becomes the multiplicand of the next column
        prod  <= PROD_W'(col_dec) * PROD_W'(rd.mag);
        sat_a <= rd.sat;
        col   <= col_dec;
      end
      OP_IDLE, OP_ROW_END, OP_READOUT: begin
      end
    endcase
    if (cmd.out_load) begin
      result.ways     <= WAYS_W'(rd.mag);
      result.overflow <= rd.sat;
    end
  end

  a_step_col_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_STEP |-> col != '0)
    else $error("column update issued at column zero");

  a_init_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_INIT |-> col <= k_q)
    else $error("row clear ran past the subset count");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_ROW_START |-> i_cnt < n_q)
    else $error("row started beyond the element count");

endmodule

>>> rtl/skdp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skdp_ctrl: query sequencer
// Walks init, row and column steps and owns both handshakes.
// ----------------------------------------------------------------------------
module skdp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   query_valid,
  output logic                   query_ready,
  output logic                   result_valid,
  input  logic                   result_ready,
  input  skdp_pkg::skdp_status_t status,
  output skdp_pkg::skdp_cmd_t    cmd
);

  import skdp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ROW_START,
    S_FETCH,
    S_STEP,
    S_ROW_END,
    S_READ,
    S_RESULT
  } state_t;

  state_t state;

  assign query_ready = (state == S_IDLE);

  always_comb begin
    cmd.out_load = 1'b0;
    unique case (state)
      S_IDLE:      cmd.op = query_valid ? OP_LOAD : OP_IDLE;
      S_INIT:      cmd.op = OP_INIT;
      S_ROW_START: cmd.op = OP_ROW_START;
      S_FETCH:     cmd.op = OP_FETCH;
      S_STEP:      cmd.op = OP_STEP;
      S_ROW_END:   cmd.op = OP_ROW_END;
      S_READ:      cmd.op = OP_READOUT;
      S_RESULT: begin
        cmd.op       = OP_READOUT;
        cmd.out_load = !result_valid || result_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // raise valid on a fresh result, drop it once the waiting one is taken
      if ((state == S_RESULT) && cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (query_valid) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if (status.init_done) begin
            state <= status.n_zero ? S_READ : S_ROW_START;
          end
        end
        S_ROW_START: state <= status.k_zero ? S_ROW_END : S_FETCH;
        S_FETCH:     state <= S_STEP;
        S_STEP: begin
          if (status.last_col) begin
            state <= S_ROW_END;
          end
        end
        S_ROW_END:   state <= status.last_row ? S_READ : S_ROW_START;
        S_READ:      state <= S_RESULT;
        S_RESULT: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/stirling_second_kind_dp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stirling_second_kind_dp_core: Stirling numbers of the second kind
// Answers S(n,k) per query with saturation at 2^63-1 and an overflow flag.
//
//   channel  direction  handshake                   payload
//   query    in         query_valid / query_ready   query  (elements, subsets)
//   result   out        result_valid / result_ready result (ways, overflow)
//
// A query's run time is set by the single multiply-add unit and the one read
// port of the row store: one column update per cycle, plus per-row overhead
// in the row start, fetch and row end states (no fetch state when k = 0).
// rst is synchronous and active high; it idles the sequencer and drops
// result_valid. The row store needs no clearing: each query rewrites it.
// The result register frees the core for the next query while a transaction
// waits on result_ready; a further result stalls only if that one is unread.
// ----------------------------------------------------------------------------
module stirling_second_kind_dp_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   query_valid,
  output logic                   query_ready,
  input  skdp_pkg::skdp_query_t  query,
  output logic                   result_valid,
  input  logic                   result_ready,
  output skdp_pkg::skdp_result_t result
);

  import skdp_pkg::*;

  skdp_cmd_t    cmd;
  skdp_status_t status;

  // Sequencer: accepts a query, then steps rows i = 1..n and columns k..1.
  skdp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_ready  (query_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: row store, counters, saturating j*a + b and the result register.
  skdp_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .query  (query),
    .status (status),
    .result (result)
  );

endmodule

>>> verif/skdp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skdp_result_checker: scoreboard for the Stirling number core
// Watches both channels, predicts S(n,k) for every accepted query and
// compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module skdp_result_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   query_valid,
  input  logic                   query_ready,
  input  skdp_pkg::skdp_query_t  query,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  skdp_pkg::skdp_result_t result,
  output int                     error_count,
  output int                     pending_count
);

  import skdp_pkg::*;

  localparam logic [69:0] WAYS_CAP = (70'd1 << 63) - 70'd1;

  skdp_result_t expected_results[$];
  int           errors;

  // Row store of the predictor: magnitude plus saturation mark per column.
  logic [62:0] row_mag [0:MAX_COUNT];
  bit          row_sat [0:MAX_COUNT];

  function automatic skdp_result_t count_partitions(input skdp_query_t q);
    int           n;
    int           k;
    int           i;
    int           j;
    logic [69:0]  sum;
    skdp_result_t r;
    n = int'(q.elements);
    k = int'(q.subsets);
    if (n > MAX_COUNT) n = MAX_COUNT;
    if (k > MAX_COUNT) k = MAX_COUNT;
    row_mag[0] = 63'd1;
    row_sat[0] = 1'b0;
    for (j = 1; j <= k; j++) begin
      row_mag[j] = '0;
      row_sat[j] = 1'b0;
    end
    for (i = 1; i <= n; i++) begin
      // Update in place, high column first, so column j-1 still holds row i-1.
      for (j = k; j >= 1; j--) begin
        sum = 70'(j) * 70'(row_mag[j]) + 70'(row_mag[j-1]);
        if (row_sat[j] || row_sat[j-1] || sum > WAYS_CAP) begin
          row_mag[j] = WAYS_CAP[62:0];
          row_sat[j] = 1'b1;
        end else begin
          row_mag[j] = sum[62:0];
          row_sat[j] = 1'b0;
        end
      end
      row_mag[0] = '0;
      row_sat[0] = 1'b0;
    end
    r.ways     = row_mag[k];
    r.overflow = row_sat[k];
    return r;
  endfunction

  always @(posedge clk) begin
    skdp_result_t exp_r;
    if (rst) begin
      expected_results.delete();
      errors = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no query outstanding: ways %0d overflow %0b",
                 result.ways, result.overflow);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result.ways !== exp_r.ways) begin
            $error("ways mismatch: expected %0d, actual %0d", exp_r.ways, result.ways);
            errors++;
          end
          if (result.overflow !== exp_r.overflow) begin
            $error("overflow mismatch: expected %0b, actual %0b",
                   exp_r.overflow, result.overflow);
            errors++;
          end
        end
      end
      if (query_valid && query_ready) begin
        expected_results.push_back(count_partitions(query));
      end
    end
    error_count   = errors;
    pending_count = expected_results.size();
  end

endmodule

>>> verif/tb_stirling_second_kind_dp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stirling_second_kind_dp_core: stimulus and verdict for the Stirling core
// Sends directed corner queries, then random queries under three idling
// phases, and lets the scoreboard check every result transaction.
// ----------------------------------------------------------------------------
module tb_stirling_second_kind_dp_core;
  import skdp_pkg::*;

  localparam int RANDOM_QUERIES = 118;
  // The limit covers a full 63 x 63 query, the longest one, and leaves room
  // for long receiver stalls on top of that.
  localparam int STALL_LIMIT    = 60000;
  localparam int DRAIN_CYCLES   = 100;

  logic         clk;
  logic         rst;
  logic         query_valid;
  logic         query_ready;
  skdp_query_t  query;
  logic         result_valid;
  logic         result_ready;
  skdp_result_t result;

  int error_count;
  int pending_count;
  int sender_idle_pct;
  int receiver_idle_pct;
  int stall_cycles;

  skdp_query_t directed_queries[$];

  stirling_second_kind_dp_core dut (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_ready  (query_ready),
    .query        (query),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  skdp_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .query_valid   (query_valid),
    .query_ready   (query_ready),
    .query         (query),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // 12 ns clock, rising edge at time zero.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Receiver: roll ready on every falling edge; hold it low in reset.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (query_valid && query_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic skdp_query_t make_query(input int n, input int k);
    skdp_query_t q;
    q.elements = IN_W'(n);
    q.subsets  = IN_W'(k);
    return q;
  endfunction

  // Most random queries stay small to keep the run short; some reach the
  // overflow region and a few use the full count range.
  function automatic skdp_query_t random_query();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 6) begin
      return make_query($urandom_range(0, 12), $urandom_range(0, 12));
    end else if (sel <= 8) begin
      return make_query($urandom_range(0, 40), $urandom_range(0, 40));
    end
    return make_query($urandom_range(0, MAX_COUNT), $urandom_range(0, MAX_COUNT));
  endfunction

  // Drive one query transaction: idle at random, then raise valid and hold
  // the payload until the core takes it. Returns on the falling edge after
  // acceptance, so the next call may keep valid high without a dip.
  task automatic send_query(input skdp_query_t q);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      query_valid = 1'b0;
      @(negedge clk);
    end
    query       = q;
    query_valid = 1'b1;
    @(posedge clk);
    while (!query_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has drained.
  task automatic wait_for_drain();
    query_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    int phase_len;
    int idx;

    rst               = 1'b1;
    query_valid       = 1'b0;
    query             = '0;
    sender_idle_pct   = 20;
    receiver_idle_pct = 83;

    // Corners: empty set, k above n, zero subsets, single subset, full
    // range on both fields, and queries deep into saturation.
    directed_queries.push_back(make_query(0, 0));
    directed_queries.push_back(make_query(0, 5));
    directed_queries.push_back(make_query(5, 0));
    directed_queries.push_back(make_query(1, 0));
    directed_queries.push_back(make_query(1, 1));
    directed_queries.push_back(make_query(2, 1));
    directed_queries.push_back(make_query(5, 3));
    directed_queries.push_back(make_query(10, 12));
    directed_queries.push_back(make_query(0, 63));
    directed_queries.push_back(make_query(63, 0));
    directed_queries.push_back(make_query(63, 1));
    directed_queries.push_back(make_query(63, 2));
    directed_queries.push_back(make_query(63, 10));
    directed_queries.push_back(make_query(63, 30));
    directed_queries.push_back(make_query(40, 20));
    directed_queries.push_back(make_query(25, 12));
    directed_queries.push_back(make_query(26, 13));
    directed_queries.push_back(make_query(63, 61));
    directed_queries.push_back(make_query(63, 62));
    directed_queries.push_back(make_query(63, 63));
    directed_queries.push_back(make_query(42, 21));
    directed_queries.push_back(make_query(21, 42));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (directed_queries[i]) send_query(directed_queries[i]);

    // Three phases: slow receiver, slow sender, then back-to-back.
    phase_len = RANDOM_QUERIES / 3;
    for (idx = 0; idx < RANDOM_QUERIES; idx++) begin
      if (idx == phase_len) begin
        sender_idle_pct   = 83;
        receiver_idle_pct = 20;
      end else if (idx == 2 * phase_len) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      if (idx % 37 == 36) wait_for_drain();
      send_query(random_query());
    end
    query_valid = 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/skdp_pkg.sv
rtl/skdp_ram.sv
rtl/skdp_datapath.sv
rtl/skdp_ctrl.sv
rtl/stirling_second_kind_dp_core.sv
verif/skdp_result_checker.sv
verif/tb_stirling_second_kind_dp_core.sv
